@@ design/mjd_pkg.sv @@
package mjd_pkg;

  localparam int unsigned ByteW      = 8;
  localparam int unsigned PosW       = 4;
  localparam int unsigned LineDepth  = 15;
  localparam int unsigned MaxMarkLen = 15;

  localparam int unsigned StartLen  = 12;
  localparam int unsigned HeaderLen = 4;
  localparam int unsigned EndLen    = 14;

  typedef logic [MaxMarkLen*ByteW-1:0] marker_t;
  typedef logic [ByteW-1:0]            byte_t;
  typedef logic [PosW-1:0]             pos_t;

  // Markers are right-aligned: first character in the highest used byte.
  // CR and LF are written as octal escapes (015, 012).
  localparam marker_t StartMarker  = marker_t'("--myboundary");
  localparam marker_t HeaderMarker = marker_t'("\015\012\015\012");
  localparam marker_t EndMarker    = marker_t'("\015\012--myboundary");

  function automatic byte_t mark_char(input marker_t mark, input int unsigned len,
                                      input int unsigned idx);
    return mark[(len - 1 - idx) * ByteW +: ByteW];
  endfunction

  // Next partial-match length after byte b, given a match of mp bytes.
  // The self-overlap checks fold to constants; only the byte compare and the
  // select by mp remain as logic.
  function automatic pos_t advance_match(input marker_t mark, input int unsigned len,
                                         input pos_t mp, input byte_t b);
    pos_t        res;
    pos_t        mp_c;
    logic        pm;
    int unsigned best;
    res  = '0;
    mp_c = (32'(mp) >= len) ? '0 : mp;
    for (int unsigned m = 0; m < MaxMarkLen; m++) begin
      best = 0;
      if (m < len) begin
        for (int unsigned k = 1; k <= MaxMarkLen; k++) begin
          if (k <= m + 1 && k <= len) begin
            pm = 1'b1;
            for (int unsigned j = 0; j + 1 < k; j++) begin
              if (mark_char(mark, len, j) != mark_char(mark, len, m + 1 - k + j)) begin
                pm = 1'b0;
              end
            end
            if (pm && mark_char(mark, len, k - 1) == b) begin
              best = k;
            end
          end
        end
      end
      if (32'(mp_c) == m) begin
        res = PosW'(best);
      end
    end
    return res;
  endfunction

endpackage

@@ design/mjd_if.sv @@
interface mjd_in_if import mjd_pkg::*; ();
  logic  valid;
  logic  ready;
  logic  kind;
  byte_t data_byte;

  modport source (output valid, output kind, output data_byte, input ready);
  modport sink   (input valid, input kind, input data_byte, output ready);
endinterface

interface mjd_out_if import mjd_pkg::*; ();
  logic  valid;
  logic  ready;
  byte_t payload_byte;
  logic  frame_last;
  logic  empty_frame;

  modport source (output valid, output payload_byte, output frame_last,
                  output empty_frame, input ready);
  modport sink   (input valid, input payload_byte, input frame_last,
                  input empty_frame, output ready);
endinterface

@@ design/multipart_mjpeg_deframer_core.sv @@
// A frame word is loaded into the output register when the stream word that
// releases it is accepted.
// Throughput: one stream word per cycle; input stalls only while a result
// waits in the output register and the sink holds ready low.
// Reset (rst, synchronous): back to start-boundary hunt, match and line empty.
module multipart_mjpeg_deframer_core import mjd_pkg::*; (
  input  logic clk,
  input  logic rst,
  mjd_in_if.sink    stream,
  mjd_out_if.source frame
);

  localparam logic [1:0] PH_START   = 2'd0;
  localparam logic [1:0] PH_HEADER  = 2'd1;
  localparam logic [1:0] PH_PAYLOAD = 2'd2;

  logic [1:0] phase, phase_next;
  pos_t       match_pos, match_pos_next;
  pos_t       hb_count, hb_count_next;
  byte_t      holdback [LineDepth];
  byte_t      holdback_next [LineDepth];
  byte_t      hb_w [LineDepth];

  logic  accept;
  logic  produce;
  byte_t res_byte;
  logic  res_last;
  logic  res_empty;

  pos_t  m_start, m_header, m_end;
  pos_t  wr_idx;
  pos_t  new_count;

  assign stream.ready = !frame.valid || frame.ready;
  assign accept       = stream.valid && stream.ready;

  assign m_start  = advance_match(StartMarker, StartLen, match_pos, stream.data_byte);
  assign m_header = advance_match(HeaderMarker, HeaderLen, match_pos, stream.data_byte);
  assign m_end    = advance_match(EndMarker, EndLen, match_pos, stream.data_byte);

  assign wr_idx    = (hb_count > pos_t'(LineDepth - 1)) ? pos_t'(LineDepth - 1) : hb_count;
  assign new_count = wr_idx + pos_t'(1);

  always_comb begin
    for (int unsigned i = 0; i < LineDepth; i++) begin
      hb_w[i] = holdback[i];
    end
    hb_w[wr_idx] = stream.data_byte;
  end

  always_comb begin
    phase_next     = phase;
    match_pos_next = match_pos;
    hb_count_next  = hb_count;
    holdback_next  = holdback;
    produce        = 1'b0;
    res_byte       = '0;
    res_last       = 1'b0;
    res_empty      = 1'b0;
    if (accept) begin
      if (stream.kind) begin
        phase_next     = PH_START;
        match_pos_next = '0;
        hb_count_next  = '0;
      end else begin
        unique case (phase)
          PH_HEADER: begin
            if (m_header == pos_t'(HeaderLen)) begin
              phase_next     = PH_PAYLOAD;
              match_pos_next = '0;
              hb_count_next  = '0;
            end else begin
              match_pos_next = m_header;
            end
          end
          PH_PAYLOAD: begin
            if (m_end == pos_t'(EndLen)) begin
              // end marker done: flag last byte or report empty frame
              produce        = 1'b1;
              res_last       = (new_count == pos_t'(LineDepth));
              res_empty      = !res_last;
              res_byte       = res_last ? hb_w[0] : '0;
              phase_next     = PH_HEADER;
              match_pos_next = '0;
              hb_count_next  = '0;
            end else if (new_count == pos_t'(LineDepth)) begin
              produce        = 1'b1;
              res_byte       = hb_w[0];
              match_pos_next = m_end;
              hb_count_next  = pos_t'(LineDepth - 1);
              for (int unsigned i = 0; i + 1 < LineDepth; i++) begin
                holdback_next[i] = hb_w[i + 1];
              end
            end else begin
              match_pos_next = m_end;
              hb_count_next  = new_count;
              holdback_next  = hb_w;
            end
          end
          default: begin
            if (m_start == pos_t'(StartLen)) begin
              phase_next     = PH_HEADER;
              match_pos_next = '0;
            end else begin
              phase_next     = PH_START;
              match_pos_next = m_start;
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_START;
      match_pos   <= '0;
      hb_count    <= '0;
      frame.valid <= 1'b0;
    end else begin
      phase     <= phase_next;
      match_pos <= match_pos_next;
      hb_count  <= hb_count_next;
      if (accept && produce) begin
        frame.valid <= 1'b1;
      end else if (frame.ready) begin
        frame.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    holdback <= holdback_next;
    if (accept && produce) begin
      frame.payload_byte <= res_byte;
      frame.frame_last   <= res_last;
      frame.empty_frame  <= res_empty;
    end
  end

endmodule
